[design/cam2d_pkg.sv]
// Shared constants, types and the arctangent table for the 2D camera view transform.
package cam2d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ANG_FRAC  = 30;
    localparam int MAGW      = 36;
    localparam int SW        = 62;
    localparam int QBITS     = 40;
    localparam int QW        = QBITS + 1;
    localparam int DIV_PRE   = QBITS - 2 * FRAC_BITS;

    typedef logic signed [32:0] cord_t;
    typedef logic signed [26:0] ang_t;

    localparam cord_t CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [33:0] DEG_TO_RAD = 34'sd18740330;
    localparam ang_t ANG_FULL    = 27'sd23592960;
    localparam ang_t ANG_HALF    = 27'sd11796480;
    localparam ang_t ANG_QUARTER = 27'sd5898240;

    typedef enum logic [2:0] {
        REG_TARGET_X = 3'd0,
        REG_TARGET_Y = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_OFFSET_Y = 3'd3,
        REG_UNIT_PIX = 3'd4,
        REG_ZOOM     = 3'd5,
        REG_ANGLE    = 3'd6
    } reg_idx_t;

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    function automatic cord_t atan_entry(input logic [4:0] idx);
        return $signed({3'b000, ATAN_TAB[idx]});
    endfunction

endpackage

[design/cam2d_cordic.sv]
// Iterative rotation-mode CORDIC producing cosine and sine with 30 fraction bits.
module cam2d_cordic
    import cam2d_pkg::*;
#(
    parameter int STEPS = 20
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  cord_t z_init,
    output logic  done,
    output cord_t cos_out,
    output cord_t sin_out
);

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic {C_IDLE, C_RUN} cstate_t;

    cstate_t         state_reg;
    logic [IW-1:0]   iter_reg;
    cord_t           x_reg, y_reg, z_reg;
    cord_t           x_next, y_next, z_next, sx, sy, at;
    logic            done_reg;

    always_comb
    begin
        sx = x_reg >>> iter_reg;
        sy = y_reg >>> iter_reg;
        at = atan_entry(5'(iter_reg));
        if (!z_reg[32])
        begin
            x_next = x_reg - sy;
            y_next = y_reg + sx;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + sy;
            y_next = y_reg - sx;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            iter_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= CORDIC_GAIN;
                        y_reg     <= '0;
                        z_reg     <= z_init;
                        iter_reg  <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                    z_reg <= z_next;
                    if (iter_reg == IW'(STEPS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

[design/cam2d_div.sv]
// Serial restoring divider computing (mag << 32) / scale clamped to 2^40, one quotient bit per cycle.
module cam2d_div
    import cam2d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [MAGW-1:0] mag,
    input  logic [SW-1:0]   scale,
    output logic            done,
    output logic [QW-1:0]   quot
);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t          state_reg;
    logic [5:0]       cnt_reg;
    logic [SW:0]      rem_reg;
    logic [QBITS-1:0] feed_reg;
    logic [QW-1:0]    q_reg;
    logic             done_reg;
    logic [SW:0]      trial;
    logic             fits;
    logic             big;

    // The quotient reaches the clamp exactly when mag is at least scale shifted by 8.
    assign big   = {{(SW + DIV_PRE - MAGW){1'b0}}, mag} >= {scale, {DIV_PRE{1'b0}}};
    assign trial = {rem_reg[SW-1:0], feed_reg[QBITS-1]};
    assign fits  = trial >= {1'b0, scale};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            feed_reg  <= '0;
            q_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        if (big)
                        begin
                            q_reg    <= QW'(1) << QBITS;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            rem_reg   <= (SW + 1)'(mag >> DIV_PRE);
                            feed_reg  <= {mag[DIV_PRE-1:0], {(2 * FRAC_BITS){1'b0}}};
                            q_reg     <= '0;
                            cnt_reg   <= '0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg  <= fits ? (trial - {1'b0, scale}) : trial;
                    q_reg    <= {q_reg[QW-2:0], fits};
                    feed_reg <= {feed_reg[QBITS-2:0], 1'b0};
                    if (cnt_reg == 6'(QBITS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[design/camera_2d_view_transform.sv]
// Top level of the 2D camera view transform with sequencer and shared multiplier.
// Usage: program the seven camera registers through the cfg channel (index 0..6,
// unknown indexes are ignored) while the block is idle, then send points on the
// in channel with kind 0 for world to screen or kind 1 for screen to world.
// Each point yields exactly one transfer on the out channel carrying out_x, out_y,
// the saturated flag and the zero_scale flag.
// One item is processed at a time; in_ready is high only when the sequencer idles,
// so the next point is accepted at the earliest in the cycle after a result is loaded.
// A single 34x34 multiplier is reused for the scale product, the degree to radian
// conversion, the rotation terms and the partial products of the forward scale.
// Each point takes the rotation through the CORDIC loop only when the angle register
// is nonzero; each coordinate then goes through the partial products of the forward
// scale for world to screen or through the serial divider for screen to world, which
// skips its loop when the quotient clamps. A zero scale in screen to world skips all
// of this. The CORDIC loop and the divider, one quotient bit per cycle, set the pace.
// The result sits in an output register, so a new point is accepted while the
// receiver stalls; a finished point then waits until the output register frees.
// Reset returns the registers to target 0, offset 0, 24 pixels per unit, zoom 1.0,
// angle 0, and empties the output register.
module camera_2d_view_transform
    import cam2d_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic               saturated,
    output logic               zero_scale
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_FOLD, S_RAD, S_CSTART, S_CWAIT, S_ROT, S_ROTEND,
        S_MAG, S_MUL, S_MEND, S_DSTART, S_DWAIT, S_FIN, S_DONE
    } state_t;

    localparam logic signed [66:0] RND = 67'sd1 <<< (ANG_FRAC - 1);
    localparam logic signed [42:0] SAT_MAX = 43'sd2147483647;
    localparam logic signed [42:0] SAT_MIN = -43'sd2147483648;

    // Camera registers.
    logic signed [31:0] tx_reg, ty_reg, ox_reg, oy_reg;
    logic [30:0]        up_reg, zoom_reg;
    logic signed [25:0] ang_cfg_reg;

    // Sequencer and datapath.
    state_t             state_reg;
    logic [2:0]         cnt_reg;
    logic               inv_reg, sel_reg, neg_reg, sneg_reg, cneg_reg;
    ang_t               ang_reg;
    logic [22:0]        a_reg;
    logic [SW-1:0]      s_reg;
    logic signed [35:0] vx_reg, vy_reg;
    logic signed [31:0] co_reg, si_reg;
    logic signed [66:0] accx_reg, accy_reg;
    logic [97:0]        acc_reg;
    logic [MAGW-1:0]    mag_reg;
    logic [QW-1:0]      res_mag_reg;
    logic signed [31:0] resx_reg, resy_reg;
    logic               sat_reg, zs_reg;
    logic signed [67:0] prod_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic               out_sat_reg, out_zs_reg;

    logic signed [33:0] mul_a, mul_b;
    ang_t               ang_ext, ang_red, ang_abs;
    logic signed [35:0] base_x, base_y, v_sel;
    logic [6:0]         pp_shift;
    logic signed [42:0] fin_mag, fin_base, fin_sum;
    logic               cor_start, cor_done, div_start, div_done;
    cord_t              cor_z, cor_cos, cor_sin;
    logic [QW-1:0]      div_quot;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg      <= '0;
            ty_reg      <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            up_reg      <= 31'(24) << FRAC_BITS;
            zoom_reg    <= 31'(1) << FRAC_BITS;
            ang_cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET_X: tx_reg      <= cfg_data;
                REG_TARGET_Y: ty_reg      <= cfg_data;
                REG_OFFSET_X: ox_reg      <= cfg_data;
                REG_OFFSET_Y: oy_reg      <= cfg_data;
                REG_UNIT_PIX: up_reg      <= cfg_data[30:0];
                REG_ZOOM:     zoom_reg    <= cfg_data[30:0];
                REG_ANGLE:    ang_cfg_reg <= cfg_data[25:0];
                default:      ;
            endcase
        end
    end

    // First half of the modulo 360 reduction, taken at input transfer.
    always_comb
    begin
        ang_ext = 27'(ang_cfg_reg);
        if (ang_ext >= ANG_FULL)
            ang_red = ang_ext - ANG_FULL;
        else if (ang_ext <= -ANG_FULL)
            ang_red = ang_ext + ANG_FULL;
        else
            ang_red = ang_ext;
        ang_abs = ang_reg[26] ? -ang_reg : ang_reg;
    end

    assign base_x = kind ? 36'(ox_reg) : 36'(tx_reg);
    assign base_y = kind ? 36'(oy_reg) : 36'(ty_reg);
    assign v_sel  = sel_reg ? vy_reg : vx_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SCALE:
            begin
                mul_a = $signed({3'b000, up_reg});
                mul_b = $signed({3'b000, zoom_reg});
            end
            S_RAD:
            begin
                mul_a = $signed({11'd0, a_reg});
                mul_b = DEG_TO_RAD;
            end
            S_ROT:
            begin
                mul_a = (cnt_reg[0]) ? 34'(vy_reg) : 34'(vx_reg);
                case (cnt_reg)
                    3'd0, 3'd3: mul_b = 34'(co_reg);
                    default:    mul_b = 34'(si_reg);
                endcase
            end
            S_MUL:
            begin
                mul_a = cnt_reg[0] ? $signed({16'd0, mag_reg[35:18]})
                                   : $signed({16'd0, mag_reg[17:0]});
                mul_b = cnt_reg[1] ? $signed({3'b000, s_reg[61:31]})
                                   : $signed({3'b000, s_reg[30:0]});
            end
            default: ;
        endcase
    end

    // Weight of the partial product that arrives this cycle.
    always_comb
    begin
        case (cnt_reg)
            3'd2:    pp_shift = 7'd18;
            3'd3:    pp_shift = 7'd31;
            3'd4:    pp_shift = 7'd49;
            default: pp_shift = 7'd0;
        endcase
    end

    always_comb
    begin
        fin_mag  = neg_reg ? -$signed({2'b00, res_mag_reg}) : $signed({2'b00, res_mag_reg});
        if (inv_reg)
            fin_base = sel_reg ? 43'(ty_reg) : 43'(tx_reg);
        else
            fin_base = sel_reg ? 43'(oy_reg) : 43'(ox_reg);
        fin_sum  = fin_mag + fin_base;
    end

    assign cor_start = (state_reg == S_CSTART);
    assign cor_z     = $signed(prod_reg[48:16]);
    assign div_start = (state_reg == S_DSTART);

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            inv_reg       <= 1'b0;
            sel_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            sneg_reg      <= 1'b0;
            cneg_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            zs_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sat_reg   <= 1'b0;
            out_zs_reg    <= 1'b0;
            ang_reg       <= '0;
            a_reg         <= '0;
            s_reg         <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            co_reg        <= '0;
            si_reg        <= '0;
            accx_reg      <= '0;
            accy_reg      <= '0;
            acc_reg       <= '0;
            mag_reg       <= '0;
            res_mag_reg   <= '0;
            resx_reg      <= '0;
            resy_reg      <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
        end
        else
        begin
            // In the done state the output register is handled by that state alone.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        inv_reg   <= kind;
                        vx_reg    <= 36'(in_x) - base_x;
                        vy_reg    <= 36'(in_y) - base_y;
                        ang_reg   <= ang_red;
                        sat_reg   <= 1'b0;
                        zs_reg    <= 1'b0;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    // Second half of the reduction into (-180, 180].
                    if (ang_reg > ANG_HALF)
                        ang_reg <= ang_reg - ANG_FULL;
                    else if (ang_reg <= -ANG_HALF)
                        ang_reg <= ang_reg + ANG_FULL;
                    state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    s_reg    <= prod_reg[SW-1:0];
                    sneg_reg <= ang_reg[26];
                    cneg_reg <= ang_abs > ANG_QUARTER;
                    a_reg    <= (ang_abs > ANG_QUARTER) ? 23'(ANG_HALF - ang_abs)
                                                         : 23'(ang_abs);
                    sel_reg  <= 1'b0;
                    if (inv_reg && (prod_reg[SW-1:0] == '0))
                    begin
                        resx_reg  <= '0;
                        resy_reg  <= '0;
                        zs_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (ang_cfg_reg == '0)
                        state_reg <= S_MAG;
                    else
                        state_reg <= S_RAD;
                end
                S_RAD:    state_reg <= S_CSTART;
                S_CSTART: state_reg <= S_CWAIT;
                S_CWAIT:
                begin
                    if (cor_done)
                    begin
                        co_reg    <= cneg_reg ? 32'(-cor_cos) : 32'(cor_cos);
                        si_reg    <= (sneg_reg ^ inv_reg) ? 32'(-cor_sin) : 32'(cor_sin);
                        cnt_reg   <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    case (cnt_reg)
                        3'd1: accx_reg <= RND + 67'(prod_reg);
                        3'd2: accx_reg <= accx_reg - 67'(prod_reg);
                        3'd3: accy_reg <= RND + 67'(prod_reg);
                        3'd4:
                        begin
                            accy_reg  <= accy_reg + 67'(prod_reg);
                            state_reg <= S_ROTEND;
                        end
                        default: ;
                    endcase
                end
                S_ROTEND:
                begin
                    vx_reg    <= accx_reg[65:30];
                    vy_reg    <= accy_reg[65:30];
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    neg_reg   <= v_sel[35];
                    mag_reg   <= v_sel[35] ? MAGW'(-v_sel) : MAGW'(v_sel);
                    cnt_reg   <= '0;
                    acc_reg   <= '0;
                    state_reg <= inv_reg ? S_DSTART : S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != 3'd0)
                        acc_reg <= acc_reg + (98'(prod_reg[48:0]) << pp_shift);
                    if (cnt_reg == 3'd4)
                        state_reg <= S_MEND;
                end
                S_MEND:
                begin
                    res_mag_reg <= (acc_reg[97:72] != '0) ? (QW'(1) << QBITS)
                                                          : {1'b0, acc_reg[71:32]};
                    state_reg   <= S_FIN;
                end
                S_DSTART: state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        res_mag_reg <= div_quot;
                        state_reg   <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (fin_sum > SAT_MAX)
                    begin
                        sat_reg <= 1'b1;
                        if (sel_reg) resy_reg <= 32'(SAT_MAX);
                        else         resx_reg <= 32'(SAT_MAX);
                    end
                    else if (fin_sum < SAT_MIN)
                    begin
                        sat_reg <= 1'b1;
                        if (sel_reg) resy_reg <= 32'(SAT_MIN);
                        else         resx_reg <= 32'(SAT_MIN);
                    end
                    else
                    begin
                        if (sel_reg) resy_reg <= 32'(fin_sum);
                        else         resx_reg <= 32'(fin_sum);
                    end
                    if (sel_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_MAG;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= resx_reg;
                        out_y_reg     <= resy_reg;
                        out_sat_reg   <= sat_reg;
                        out_zs_reg    <= zs_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    cam2d_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .z_init  (cor_z),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    cam2d_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (mag_reg),
        .scale (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign saturated  = out_sat_reg;
    assign zero_scale = out_zs_reg;

    a_zero_scale_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_scale |-> out_x == 0 && out_y == 0 && !saturated)
        else $error("zero scale result carries nonzero payload");

    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> state_reg == S_CWAIT)
        else $error("CORDIC finished outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait state");

endmodule

[sim/camera_2d_view_transform_checker.sv]
// Checker for the 2D camera view transform: predicts each point's result and compares.
module camera_2d_view_transform_checker
    import cam2d_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic               saturated,
    input  logic               zero_scale,
    output int                 pending,
    output int                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
        logic               zs;
    } view_result_t;

    logic [31:0] cam_reg [7];
    view_result_t expected_views [$];

    assign pending = expected_views.size();

    // Cosine and sine of the angle register, 30 fraction bits.
    task automatic angle_sincos(output longint co, output longint si);
        longint full, half, quarter, d, a, x, y, z, nx;
        bit sneg, cneg;
        full = longint'(ANG_FULL);
        half = longint'(ANG_HALF);
        quarter = longint'(ANG_QUARTER);
        cneg = 1'b0;
        d = longint'($signed(cam_reg[REG_ANGLE][25:0])) % full;
        if (d > half) d -= full;
        if (d <= -half) d += full;
        sneg = d < 0;
        a = sneg ? -d : d;
        if (a > quarter)
        begin
            a = half - a;
            cneg = 1'b1;
        end
        z = (a * longint'(DEG_TO_RAD)) >>> FRAC_BITS;
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        co = cneg ? -x : x;
        si = sneg ? -y : y;
    endtask

    // Multiply or divide by the scale on the magnitude, truncated and capped at 2^40.
    function automatic longint scale_coord(longint v, logic [63:0] s, bit divide);
        logic [127:0] mag, r;
        logic [127:0] cap;
        cap = 128'd1 << QBITS;
        mag = (v < 0) ? 128'(-v) : 128'(v);
        if (divide)
            r = (mag << (2 * FRAC_BITS)) / {64'd0, s};
        else
            r = (mag * {64'd0, s}) >> (2 * FRAC_BITS);
        if (r > cap) r = cap;
        return (v < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint clip32(longint v, ref bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    task automatic predict_view(input logic inv, input logic signed [31:0] px,
                                input logic signed [31:0] py, output view_result_t r);
        logic [63:0] s;
        longint vx, vy, co, si, rx, ry, tx, ty, ox, oy, rnd;
        bit sat;
        sat = 1'b0;
        rnd = 64'sd1 <<< (ANG_FRAC - 1);
        s = {33'd0, cam_reg[REG_UNIT_PIX][30:0]} * {33'd0, cam_reg[REG_ZOOM][30:0]};
        tx = longint'($signed(cam_reg[REG_TARGET_X]));
        ty = longint'($signed(cam_reg[REG_TARGET_Y]));
        ox = longint'($signed(cam_reg[REG_OFFSET_X]));
        oy = longint'($signed(cam_reg[REG_OFFSET_Y]));
        if (inv && s == 64'd0)
        begin
            r = '{x: 32'sd0, y: 32'sd0, sat: 1'b0, zs: 1'b1};
            return;
        end
        vx = longint'(px) - (inv ? ox : tx);
        vy = longint'(py) - (inv ? oy : ty);
        if (cam_reg[REG_ANGLE][25:0] != 26'd0)
        begin
            angle_sincos(co, si);
            if (inv) si = -si;
            rx = (vx * co - vy * si + rnd) >>> ANG_FRAC;
            ry = (vx * si + vy * co + rnd) >>> ANG_FRAC;
            vx = rx;
            vy = ry;
        end
        vx = scale_coord(vx, s, inv);
        vy = scale_coord(vy, s, inv);
        vx = clip32(vx + (inv ? tx : ox), sat);
        vy = clip32(vy + (inv ? ty : oy), sat);
        r = '{x: vx[31:0], y: vy[31:0], sat: sat, zs: 1'b0};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        view_result_t exp_view;
        if (!rst_n)
        begin
            cam_reg[REG_TARGET_X] <= 32'd0;
            cam_reg[REG_TARGET_Y] <= 32'd0;
            cam_reg[REG_OFFSET_X] <= 32'd0;
            cam_reg[REG_OFFSET_Y] <= 32'd0;
            cam_reg[REG_UNIT_PIX] <= 32'd24 << FRAC_BITS;
            cam_reg[REG_ZOOM]     <= 32'd1 << FRAC_BITS;
            cam_reg[REG_ANGLE]    <= 32'd0;
            expected_views.delete();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_view(kind, in_x, in_y, exp_view);
                expected_views.push_back(exp_view);
            end
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $display("%0t: unexpected result x=%h y=%h sat=%b zs=%b",
                             $time, out_x, out_y, saturated, zero_scale);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_view = expected_views.pop_front();
                    if (out_x !== exp_view.x || out_y !== exp_view.y
                        || saturated !== exp_view.sat || zero_scale !== exp_view.zs)
                    begin
                        $display("%0t: mismatch expected x=%h y=%h sat=%b zs=%b", $time,
                                 exp_view.x, exp_view.y, exp_view.sat, exp_view.zs);
                        $display("%0t:          actual   x=%h y=%h sat=%b zs=%b", $time,
                                 out_x, out_y, saturated, zero_scale);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // A register transfer takes effect for points accepted after it.
            if (cfg_valid && cfg_ready && cfg_index <= REG_ANGLE)
            begin
                case (cfg_index)
                    REG_UNIT_PIX, REG_ZOOM: cam_reg[cfg_index] <= {1'b0, cfg_data[30:0]};
                    REG_ANGLE:              cam_reg[cfg_index] <= {6'd0, cfg_data[25:0]};
                    default:                cam_reg[cfg_index] <= cfg_data;
                endcase
            end
        end
    end

endmodule

[sim/camera_2d_view_transform_tb.sv]
// Testbench top for the 2D camera view transform: stimulus, clock, reset and verdict.
module camera_2d_view_transform_tb;
    import cam2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int NUM_PHASES = 15;
    localparam int POINTS_PER_PHASE = 118;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               saturated;
    logic               zero_scale;
    int                 pending;
    int                 fail_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    camera_2d_view_transform u_top (.*);

    camera_2d_view_transform_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Valid stays high between back-to-back points; it drops only for a sender gap.
    task automatic send_point(input logic k, input logic [31:0] x, input logic [31:0] y);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        kind     <= k;
        in_x     <= x;
        in_y     <= y;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic program_camera(input int phase);
        logic [31:0] tx, ty, ox, oy, up, zm, ang;
        tx = rand_coord();
        ty = rand_coord();
        ox = rand_coord();
        oy = rand_coord();
        up = $urandom_range(32'h0000_1000, 32'h0040_0000);
        zm = $urandom_range(32'h0000_4000, 32'h0004_0000);
        ang = $urandom();
        case (phase)
            1:
            begin
                tx = 32'h8000_0000; ty = 32'h7fff_ffff;
                ox = 32'h7fff_ffff; oy = 32'h8000_0000;
                up = 32'hffff_ffff; zm = 32'h7fff_ffff;
                ang = 32'd360 << FRAC_BITS;
            end
            2:
            begin
                up = 32'd0;
                ang = 32'd180 << FRAC_BITS;
            end
            3:
            begin
                zm = 32'd0;
                ang = -(32'd180 << FRAC_BITS);
                write_reg(REG_UNUSED, $urandom());
            end
            4: ang = 32'h01ff_ffff;
            5: ang = 32'h0200_0000;
            6: ang = 32'd90 << FRAC_BITS;
            7: ang = -(32'd90 << FRAC_BITS);
            8: ang = 32'd0;
            default: ;
        endcase
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_UNIT_PIX, up);
        write_reg(REG_ZOOM, zm);
        write_reg(REG_ANGLE, ang);
    endtask

    initial
    begin
        logic [31:0] corner [4];
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_TARGET_X;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        kind = 1'b0;
        in_x = 32'd0;
        in_y = 32'd0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner coordinates in both directions under the reset camera.
        for (int k = 0; k < 2; k++)
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 2; j++)
                    send_point(k[0], corner[i], corner[(i + j + 1) % 4]);
        drain();

        for (int phase = 1; phase < NUM_PHASES; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            program_camera(phase);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
                send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord());
            drain();
        end

        if (fail_count == 0)
            $display("PASS camera_2d_view_transform");
        else
            $display("FAIL camera_2d_view_transform");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("FAIL camera_2d_view_transform");
        $finish;
    end

endmodule

[filelist.f]
design/cam2d_pkg.sv
design/cam2d_cordic.sv
design/cam2d_div.sv
design/camera_2d_view_transform.sv
sim/camera_2d_view_transform_checker.sv
sim/camera_2d_view_transform_tb.sv
